FILE: hw/rtl/dra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dra_pkg
// Shared types and constants of the DNS reply A record extractor.
// ----------------------------------------------------------------------------
package dra_pkg;

  // Bytes past this count in one reply are ignored up to the end mark.
  localparam int unsigned MaxMsgBytes = 512;
  localparam int unsigned PosW        = $clog2(MaxMsgBytes + 1);

  localparam int unsigned HdrBytes    = 12;
  localparam int unsigned QFixBytes   = 4;
  localparam int unsigned RHdrBytes   = 10;
  localparam int unsigned AddrBytes   = 4;
  localparam int unsigned CntW        = 4;

  localparam logic [15:0] TypeA       = 16'd1;

  // Header byte positions of the answer count and the last header byte.
  localparam logic [PosW-1:0] AnCountHiPos = PosW'(6);
  localparam logic [PosW-1:0] AnCountLoPos = PosW'(7);
  localparam logic [PosW-1:0] HdrLastPos   = PosW'(HdrBytes - 1);

  // Depth of the classified-byte queue and of the result queue.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [7:0] data;
    logic       is_zero;  // byte ends a name
    logic       is_ptr;   // byte of 192 or more: compression pointer
    logic       last;     // final byte of the reply
  } cls_byte_t;

  typedef struct packed {
    logic [31:0] ipv4_addr;
    logic        found;
  } result_t;

  typedef enum logic [9:0] {
    PhHdr   = 10'b00_0000_0001,
    PhQName = 10'b00_0000_0010,
    PhQFix  = 10'b00_0000_0100,
    PhAName = 10'b00_0000_1000,
    PhAPtr  = 10'b00_0001_0000,
    PhRHdr  = 10'b00_0010_0000,
    PhAddr  = 10'b00_0100_0000,
    PhRData = 10'b00_1000_0000,
    PhDPtr  = 10'b01_0000_0000,
    PhDone  = 10'b10_0000_0000
  } phase_e;

endpackage : dra_pkg
`default_nettype wire

FILE: hw/rtl/dra_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dra_front
// Accept reply bytes, tag name-ending and pointer bytes, queue them.
// ----------------------------------------------------------------------------
module dra_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              end_of_msg_i,
  output logic                   cls_valid_o,
  output dra_pkg::cls_byte_t     cls_item_o,
  input  wire logic              cls_take_i
);
  import dra_pkg::*;

  cls_byte_t              q_mem [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;
  logic                   wr_en;
  logic                   rd_en;
  cls_byte_t              cls_new;

  assign full        = (cnt_q == QCntW'(QDepth));
  assign wr_en       = push && !full;
  assign cls_valid_o = (cnt_q != '0);
  assign rd_en       = cls_take_i && cls_valid_o;
  assign cls_item_o  = q_mem[rd_ptr_q];

  always_comb begin
    cls_new.data    = rx_byte_i;
    cls_new.is_zero = (rx_byte_i == 8'd0);
    cls_new.is_ptr  = rx_byte_i[7] & rx_byte_i[6];
    cls_new.last    = end_of_msg_i;
  end

  always_comb begin
    wr_ptr_d = wr_en ? QPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = rd_en ? QPtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = QCntW'(cnt_q + 1'b1);
    end else if (rd_en && !wr_en) begin
      cnt_d = QCntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= cls_new;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("front queue count out of range");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (cnt_q == QCntW'($past(cnt_q) + 1'b1)))
    else $error("front queue count missed a write");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QCntW'(QDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("front queue pointers disagree with count");

endmodule : dra_front
`default_nettype wire

FILE: hw/rtl/dra_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dra_back
// Walk the reply sections on classified bytes and queue the result.
// ----------------------------------------------------------------------------
module dra_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cls_valid_i,
  input  wire dra_pkg::cls_byte_t cls_item_i,
  output logic                   cls_take_o,
  output logic                   empty,
  input  wire logic              pop,
  output logic [31:0]            ipv4_addr_o,
  output logic                   found_o
);
  import dra_pkg::*;

  phase_e             phase_q, phase_d;
  logic [PosW-1:0]    byte_pos_q, byte_pos_d;
  logic [15:0]        answers_q, answers_d;
  logic [15:0]        rec_type_q, rec_type_d;
  logic [31:0]        addr_q, addr_d;
  logic               reported_q, reported_d;
  logic [CntW-1:0]    field_cnt_q, field_cnt_d;

  result_t            res_mem [QDepth];
  logic [QPtrW-1:0]   res_wr_q, res_rd_q;
  logic [QCntW-1:0]   res_cnt_q, res_cnt_d;
  logic               res_push;
  logic               res_pop;
  result_t            res_new;

  logic [7:0]         b;
  logic [15:0]        answers_dec;

  assign b           = cls_item_i.data;
  assign cls_take_o  = cls_valid_i && (res_cnt_q != QCntW'(QDepth));
  assign answers_dec = answers_q - 16'd1;

  always_comb begin
    phase_d     = phase_q;
    byte_pos_d  = byte_pos_q;
    answers_d   = answers_q;
    rec_type_d  = rec_type_q;
    addr_d      = addr_q;
    reported_d  = reported_q;
    field_cnt_d = field_cnt_q;
    res_push    = 1'b0;
    res_new     = '0;

    if (cls_take_o) begin
      if (!reported_q && (byte_pos_q < PosW'(MaxMsgBytes))) begin
        case (phase_q)
          PhHdr: begin
            if (byte_pos_q == AnCountHiPos) answers_d = {b, 8'h00};
            if (byte_pos_q == AnCountLoPos) answers_d = {answers_q[15:8], b};
            if (byte_pos_q == HdrLastPos)   phase_d   = PhQName;
          end
          PhQName: begin
            if (cls_item_i.is_zero) begin
              phase_d     = PhQFix;
              field_cnt_d = '0;
            end
          end
          PhQFix: begin
            field_cnt_d = CntW'(field_cnt_q + 1'b1);
            if (field_cnt_q == CntW'(QFixBytes - 1)) begin
              field_cnt_d = '0;
              phase_d     = (answers_q == '0) ? PhDone : PhAName;
            end
          end
          PhAName: begin
            if (cls_item_i.is_zero) begin
              phase_d     = PhRHdr;
              field_cnt_d = '0;
              rec_type_d  = '0;
            end else if (cls_item_i.is_ptr) begin
              phase_d = PhAPtr;
            end
          end
          PhAPtr: begin
            phase_d     = PhRHdr;
            field_cnt_d = '0;
            rec_type_d  = '0;
          end
          PhRHdr: begin
            if (field_cnt_q == CntW'(0)) rec_type_d = {b, 8'h00};
            if (field_cnt_q == CntW'(1)) rec_type_d = {rec_type_q[15:8], b};
            field_cnt_d = CntW'(field_cnt_q + 1'b1);
            if (field_cnt_q == CntW'(RHdrBytes - 1)) begin
              field_cnt_d = '0;
              if (rec_type_q == TypeA) begin
                phase_d = PhAddr;
                addr_d  = '0;
              end else begin
                phase_d = PhRData;
              end
            end
          end
          PhAddr: begin
            addr_d      = {addr_q[23:0], b};
            field_cnt_d = CntW'(field_cnt_q + 1'b1);
            if (field_cnt_q == CntW'(AddrBytes - 1)) begin
              res_push          = 1'b1;
              res_new.ipv4_addr = {addr_q[23:0], b};
              res_new.found     = 1'b1;
              reported_d        = 1'b1;
              phase_d           = PhDone;
              field_cnt_d       = '0;
            end
          end
          PhRData: begin
            if (cls_item_i.is_zero) begin
              answers_d   = answers_dec;
              phase_d     = (answers_dec == '0) ? PhDone : PhAName;
              field_cnt_d = '0;
            end else if (cls_item_i.is_ptr) begin
              phase_d = PhDPtr;
            end
          end
          PhDPtr: begin
            answers_d   = answers_dec;
            phase_d     = (answers_dec == '0) ? PhDone : PhAName;
            field_cnt_d = '0;
          end
          default: begin
          end
        endcase
        byte_pos_d = PosW'(byte_pos_q + 1'b1);
      end

      if (cls_item_i.last) begin
        if (!reported_d) begin
          res_push = 1'b1;
          res_new  = '0;
        end
        phase_d     = PhHdr;
        byte_pos_d  = '0;
        answers_d   = '0;
        rec_type_d  = '0;
        addr_d      = '0;
        reported_d  = 1'b0;
        field_cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdr;
      byte_pos_q  <= '0;
      answers_q   <= '0;
      rec_type_q  <= '0;
      addr_q      <= '0;
      reported_q  <= 1'b0;
      field_cnt_q <= '0;
    end else begin
      phase_q     <= phase_d;
      byte_pos_q  <= byte_pos_d;
      answers_q   <= answers_d;
      rec_type_q  <= rec_type_d;
      addr_q      <= addr_d;
      reported_q  <= reported_d;
      field_cnt_q <= field_cnt_d;
    end
  end

  // Result queue.
  assign empty       = (res_cnt_q == '0);
  assign res_pop     = pop && !empty;
  assign ipv4_addr_o = res_mem[res_rd_q].ipv4_addr;
  assign found_o     = res_mem[res_rd_q].found;

  always_comb begin
    res_cnt_d = res_cnt_q;
    if (res_push && !res_pop) begin
      res_cnt_d = QCntW'(res_cnt_q + 1'b1);
    end else if (res_pop && !res_push) begin
      res_cnt_d = QCntW'(res_cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) res_wr_q <= QPtrW'(res_wr_q + 1'b1);
      if (res_pop)  res_rd_q <= QPtrW'(res_rd_q + 1'b1);
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem[res_wr_q] <= res_new;
    end
  end

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= QCntW'(QDepth))
    else $error("result queue count out of range");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_take_o && cls_item_i.last) |=>
      (phase_q == PhHdr && byte_pos_q == '0 && !reported_q))
    else $error("parser not back at header after end mark");

  a_found_from_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_new.found) |-> (phase_q == PhAddr && !reported_q))
    else $error("address result outside the address field");

  a_reported_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> (phase_q == PhDone))
    else $error("reported flag set while still parsing");

endmodule : dra_back
`default_nettype wire

FILE: hw/rtl/dns_reply_a_record_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_reply_a_record_extractor
// Scan a DNS reply byte stream and return the first A record address.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  bytes   | in        | push / full          | rx_byte_i[7:0], end_of_msg_i
//  result  | out       | pop / empty          | ipv4_addr_o[31:0], found_o
//
//  One reply byte is taken every cycle while full is low; the parser step is
//  a single registered phase update, so steady state is one byte per clock
//  while the result queue has room. A result reaches the ports through the
//  byte queue register, then the result queue register.
//  Exactly one result is produced per reply: the address on the fourth
//  address byte, or zero with found clear at the end mark.
//  full rises only when the byte queue holds two entries, which happens
//  when the result queue is full and the parser stalls.
//  Reset clears both queues and returns the parser to the header phase.
// ----------------------------------------------------------------------------
module dns_reply_a_record_extractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        end_of_msg_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      ipv4_addr_o,
  output logic             found_o
);
  import dra_pkg::*;

  logic      cls_valid;
  logic      cls_take;
  cls_byte_t cls_item;

  // Front: accept the byte, tag zero and pointer bytes, hold in a short queue.
  dra_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .rx_byte_i    (rx_byte_i),
    .end_of_msg_i (end_of_msg_i),
    .cls_valid_o  (cls_valid),
    .cls_item_o   (cls_item),
    .cls_take_i   (cls_take)
  );

  // Back: advance the section walker and queue the result transaction.
  dra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (cls_valid),
    .cls_item_i  (cls_item),
    .cls_take_o  (cls_take),
    .empty       (empty),
    .pop         (pop),
    .ipv4_addr_o (ipv4_addr_o),
    .found_o     (found_o)
  );

endmodule : dns_reply_a_record_extractor
`default_nettype wire

FILE: tb/tb_dns_reply_a_record_extractor.sv
// ----------------------------------------------------------------------------
// tb_dns_reply_a_record_extractor
// Self-checking bench for the DNS reply A record extractor. Stream whole
// replies byte by byte (directed corner messages, then random well-formed,
// truncated, overlong and noise replies), predict the single result of each
// reply in a scoreboard and compare every popped result field by field.
// Both queue sides idle at random rates that change over three phases.
// ----------------------------------------------------------------------------
module tb_dns_reply_a_record_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import dra_pkg::*;

  // Owner and record data names end on a zero or on a pointer byte at or above this value.
  localparam logic [7:0] PtrMin      = 8'd192;
  localparam int unsigned TargetBytes = 1750;
  localparam int unsigned MinReplies  = 40;
  localparam int unsigned TailCycles  = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: track the parser state per byte and hold the awaited results.
  // --------------------------------------------------------------------------
  class a_record_scoreboard;
    phase_e      phase;
    int unsigned pos;
    logic [15:0] answers_left;
    logic [15:0] rr_type;
    logic [31:0] addr_acc;
    bit          reported;
    int unsigned field_cnt;
    result_t     awaited_q[$];
    int unsigned n_mismatch;
    int unsigned n_results;
    int unsigned n_found;

    function new();
      n_mismatch = 0;
      n_results  = 0;
      n_found    = 0;
      clear_reply();
    endfunction

    function void clear_reply();
      phase        = PhHdr;
      pos          = 0;
      answers_left = '0;
      rr_type      = '0;
      addr_acc     = '0;
      reported     = 1'b0;
      field_cnt    = 0;
    endfunction

    function void step_answer();
      answers_left = answers_left - 16'd1;
      phase        = (answers_left == 16'd0) ? PhDone : PhAName;
      field_cnt    = 0;
    endfunction

    // Note one accepted reply byte.
    function void note_byte(input logic [7:0] b, input logic is_last);
      result_t r;
      if (!reported && pos < MaxMsgBytes) begin
        case (phase)
          PhHdr: begin
            if (pos == AnCountHiPos) answers_left = {b, 8'h00};
            if (pos == AnCountLoPos) answers_left[7:0] = b;
            if (pos == HdrLastPos) phase = PhQName;
          end
          PhQName: begin
            if (b == 8'h00) begin
              phase     = PhQFix;
              field_cnt = 0;
            end
          end
          PhQFix: begin
            field_cnt++;
            if (field_cnt >= QFixBytes) begin
              field_cnt = 0;
              phase     = (answers_left == 16'd0) ? PhDone : PhAName;
            end
          end
          PhAName: begin
            if (b == 8'h00) begin
              phase     = PhRHdr;
              field_cnt = 0;
              rr_type   = '0;
            end else if (b >= PtrMin) begin
              phase = PhAPtr;
            end
          end
          PhAPtr: begin
            phase     = PhRHdr;
            field_cnt = 0;
            rr_type   = '0;
          end
          PhRHdr: begin
            if (field_cnt == 0) rr_type = {b, 8'h00};
            if (field_cnt == 1) rr_type[7:0] = b;
            field_cnt++;
            if (field_cnt >= RHdrBytes) begin
              field_cnt = 0;
              if (rr_type == TypeA) begin
                phase    = PhAddr;
                addr_acc = '0;
              end else begin
                phase = PhRData;
              end
            end
          end
          PhAddr: begin
            addr_acc = {addr_acc[23:0], b};
            field_cnt++;
            if (field_cnt >= AddrBytes) begin
              r.ipv4_addr = addr_acc;
              r.found     = 1'b1;
              awaited_q.push_back(r);
              reported  = 1'b1;
              phase     = PhDone;
              field_cnt = 0;
            end
          end
          PhRData: begin
            if (b == 8'h00) step_answer();
            else if (b >= PtrMin) phase = PhDPtr;
          end
          PhDPtr: step_answer();
          default: ;
        endcase
        pos++;
      end
      if (is_last) begin
        if (!reported) begin
          r.ipv4_addr = '0;
          r.found     = 1'b0;
          awaited_q.push_back(r);
        end
        clear_reply();
      end
    endfunction

    // Check one popped result against the oldest awaited one.
    function void check_result(input logic [31:0] addr, input logic found);
      result_t r;
      n_results++;
      if (found) n_found++;
      if (awaited_q.size() == 0) begin
        $error("unexpected result: ipv4_addr %h found %b", addr, found);
        n_mismatch++;
      end else begin
        r = awaited_q.pop_front();
        if (addr !== r.ipv4_addr) begin
          $error("ipv4_addr mismatch: expected %h, actual %h", r.ipv4_addr, addr);
          n_mismatch++;
        end
        if (found !== r.found) begin
          $error("found mismatch: expected %b, actual %b", r.found, found);
          n_mismatch++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [7:0]  rx_byte_i    = '0;
  logic        end_of_msg_i = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [31:0] ipv4_addr_o;
  logic        found_o;

  a_record_scoreboard sb;
  logic [7:0]  reply_q[$];
  int unsigned send_gap_pct  = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned bytes_sent    = 0;
  int unsigned replies_sent  = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  dns_reply_a_record_extractor uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .rx_byte_i    (rx_byte_i),
    .end_of_msg_i (end_of_msg_i),
    .empty        (empty),
    .pop          (pop),
    .ipv4_addr_o  (ipv4_addr_o),
    .found_o      (found_o)
  );

  // Result side: check the transaction seen at this edge, then decide
  // whether to pop at the next one. Values read here are pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(ipv4_addr_o, found_o);
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Byte side
  // --------------------------------------------------------------------------

  // Idle at random, then hold the byte until full is low at an edge.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    rx_byte_i    <= b;
    end_of_msg_i <= is_last;
    do @(posedge clk_i); while (full);
    sb.note_byte(b, is_last);
    bytes_sent++;
  endtask

  // Send the reply held in reply_q, end mark on its last byte.
  task automatic send_reply();
    for (int i = 0; i < reply_q.size(); i++) send_byte(reply_q[i], i == reply_q.size() - 1);
    replies_sent++;
  endtask

  // Drop push and hold off until every awaited result has been popped.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.awaited_q.size() != 0);
  endtask

  // Append a name: either a compression pointer or labels closed by a zero.
  function automatic void add_name();
    int unsigned n;
    if ($urandom_range(0, 9) < 3) begin
      reply_q.push_back(8'($urandom_range(PtrMin, 255)));
      reply_q.push_back(8'($urandom));
    end else begin
      n = $urandom_range(0, 5);
      repeat (n) reply_q.push_back(8'($urandom_range(1, PtrMin - 1)));
      reply_q.push_back(8'h00);
    end
  endfunction

  // Build a reply with a random answer section. The answer count in the
  // header mostly matches the section, sometimes not. An overlong reply
  // pads the question name so the answers straddle the byte limit.
  function automatic void build_reply(input bit overlong);
    int unsigned n_ans;
    int unsigned qlen;
    logic [15:0] an_count;
    logic [15:0] rtype;
    reply_q.delete();
    n_ans = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0:       an_count = 16'd0;
      1:       an_count = 16'hFFFF;
      2:       an_count = 16'($urandom_range(0, 5));
      default: an_count = 16'(n_ans);
    endcase
    repeat (6) reply_q.push_back(8'($urandom));
    reply_q.push_back(an_count[15:8]);
    reply_q.push_back(an_count[7:0]);
    repeat (4) reply_q.push_back(8'($urandom));
    // Question name ends on a zero only; any other byte is label data here.
    qlen = overlong ? $urandom_range(470, 500) : $urandom_range(0, 6);
    repeat (qlen) reply_q.push_back(8'($urandom_range(1, 255)));
    reply_q.push_back(8'h00);
    repeat (QFixBytes) reply_q.push_back(8'($urandom));
    repeat (n_ans) begin
      add_name();
      case ($urandom_range(0, 5))
        3:       rtype = 16'h0100;
        4:       rtype = 16'd5;
        5:       rtype = 16'($urandom);
        default: rtype = TypeA;
      endcase
      reply_q.push_back(rtype[15:8]);
      reply_q.push_back(rtype[7:0]);
      repeat (RHdrBytes - 2) reply_q.push_back(8'($urandom));
      if (rtype == TypeA) begin
        case ($urandom_range(0, 9))
          0:       repeat (AddrBytes) reply_q.push_back(8'h00);
          1:       repeat (AddrBytes) reply_q.push_back(8'hFF);
          default: repeat (AddrBytes) reply_q.push_back(8'($urandom));
        endcase
      end else begin
        add_name();
      end
    end
    // Trailing bytes follow the answer section; they are parsed as answers when the count is too high.
    repeat ($urandom_range(0, 3)) reply_q.push_back(8'($urandom));
  endfunction

  // Cut a reply short at a random byte.
  function automatic void truncate_reply();
    int unsigned keep;
    keep = $urandom_range(1, reply_q.size());
    while (reply_q.size() > keep) void'(reply_q.pop_back());
  endfunction

  function automatic void build_noise();
    reply_q.delete();
    repeat ($urandom_range(1, 40)) reply_q.push_back(8'($urandom));
  endfunction

  // Pick the idle rates of the byte and result sides for one phase.
  task automatic set_idle(input int unsigned ph);
    case (ph)
      0:       begin send_gap_pct = 17; pop_stall_pct = 81; end
      1:       begin send_gap_pct = 81; pop_stall_pct = 17; end
      default: begin send_gap_pct = 0;  pop_stall_pct = 0;  end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned cur_ph;
    sb = new();
    set_idle(0);
    ph = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-byte replies at both byte extremes (short message).
    reply_q = '{8'h00};
    send_reply();
    reply_q = '{8'hFF};
    send_reply();
    // Directed: zero answers, root question name, then bytes that are ignored.
    reply_q = '{8'hAB, 8'hCD, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
                8'h01, 8'hC0, 8'h0C};
    send_reply();

    // Random: mostly well-formed replies, some cut short, some noise.
    while (bytes_sent < TargetBytes || replies_sent < MinReplies) begin
      cur_ph = (bytes_sent * 3) / TargetBytes;
      if (cur_ph > 2) cur_ph = 2;
      if (cur_ph != ph) begin
        // Hold the byte side until the result side has caught up.
        drain();
        ph = cur_ph;
        set_idle(ph);
      end
      if (replies_sent % 24 == 17) begin
        build_reply(1'b1);
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2:    build_noise();
          3, 4, 5:    begin build_reply(1'b0); truncate_reply(); end
          default:    build_reply(1'b0);
        endcase
      end
      send_reply();
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d reply bytes in %0d replies, including cut, overlong and noise ones.",
             bytes_sent, replies_sent);
    $display("Checked %0d results, %0d of them carrying an address.",
             sb.n_results, sb.n_found);
    if (sb.n_mismatch == 0 && sb.awaited_q.size() == 0) begin
      $display("tb_dns_reply_a_record_extractor passed");
    end else begin
      $display("tb_dns_reply_a_record_extractor failed");
    end
    $finish;
  end

  // Watchdog: stop a run that hangs on a handshake.
  initial begin
    #2_000_000;
    $display("tb_dns_reply_a_record_extractor failed");
    $finish;
  end

endmodule
